// ===== rtl/ovl_pkg.sv =====
// Package for the ordered value list: action codes, transaction types, cell control.
package ovl_pkg;

	localparam int OVL_CAPACITY = 16;
	localparam int VALUE_W      = 32;
	localparam int COUNT_OUT_W  = 5;

	typedef enum logic [1:0] {
		ACT_HEAD   = 2'd0,
		ACT_TAIL   = 2'd1,
		ACT_REMOVE = 2'd2,
		ACT_SEARCH = 2'd3
	} action_t;

	typedef struct packed {
		action_t                    action;
		logic signed [VALUE_W-1:0]  item_value;
	} cmd_t;

	typedef struct packed {
		logic                          found;
		logic                          is_empty;
		logic signed [VALUE_W-1:0]     head_value;
		logic [COUNT_OUT_W-1:0]        entry_count;
		logic                          status;
	} result_t;

	typedef struct packed {
		logic ins_head;
		logic ins_tail;
		logic remove;
	} cell_ctl_t;

endpackage

// ===== rtl/ovl_cell.sv =====
// One list cell: holds an entry, registers its match, shifts toward head or tail.
module ovl_cell import ovl_pkg::*; (
	input  logic                      clk,
	input  cell_ctl_t                 ctl,
	input  logic signed [VALUE_W-1:0] value,
	input  logic                      valid,
	input  logic                      at_tail,
	input  logic signed [VALUE_W-1:0] left_data,
	input  logic signed [VALUE_W-1:0] right_data,
	input  logic                      hit_in,
	output logic signed [VALUE_W-1:0] data,
	output logic                      hit_out
);

	logic signed [VALUE_W-1:0] data_q;
	logic                      match_q;

	always_ff @(posedge clk) begin
		match_q <= valid && (data_q == value);
	end

	assign hit_out = hit_in | match_q;

	always_ff @(posedge clk) begin
		if (ctl.ins_head) begin
			data_q <= left_data;
		end else if (ctl.ins_tail && at_tail) begin
			data_q <= value;
		end else if (ctl.remove && hit_out) begin
			data_q <= right_data;
		end
	end

	assign data = data_q;

endmodule

// ===== rtl/ordered_value_list.sv =====
// Top level of the ordered value list: control, count and a row of list cells.
// Each transaction keeps busy high through the compare state, in which every cell
// registers whether its entry equals the value, then the update state, in which the first
// match is found along the cell row and all cells shift or load at once. The result
// is shown with done in the cycle after that, the same cycle in which the next
// transaction may be started; a new one is taken only once the last is through. The
// result cannot be held off; it is valid only while done is high.
module ordered_value_list import ovl_pkg::*; #(
	parameter int CAPACITY = OVL_CAPACITY
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    start,
	input  cmd_t    cmd,
	output logic    busy,
	output logic    done,
	output result_t result
);

	localparam int CW = $clog2(CAPACITY + 1);

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_CMP  = 3'b010,
		ST_UPD  = 3'b100
	} state_t;

	state_t                    state_q;
	logic [CW-1:0]             count_q;
	action_t                   act_s1;
	logic signed [VALUE_W-1:0] value_s1;
	logic                      found_q;
	logic                      status_q;
	logic                      done_q;

	logic                      full;
	logic                      is_ins;
	logic                      is_lookup;
	logic                      hit_last;
	cell_ctl_t                 ctl;

	logic signed [VALUE_W-1:0] cell_data [CAPACITY];
	logic                      hit_chain [CAPACITY+1];

	assign busy      = (state_q != ST_IDLE);
	assign full      = (count_q == CW'(CAPACITY));
	assign is_ins    = (act_s1 == ACT_HEAD) || (act_s1 == ACT_TAIL);
	assign is_lookup = !is_ins;
	assign hit_last  = hit_chain[CAPACITY];

	always_comb begin
		ctl.ins_head = (state_q == ST_UPD) && (act_s1 == ACT_HEAD) && !full;
		ctl.ins_tail = (state_q == ST_UPD) && (act_s1 == ACT_TAIL) && !full;
		ctl.remove   = (state_q == ST_UPD) && (act_s1 == ACT_REMOVE);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			count_q  <= '0;
			done_q   <= 1'b0;
			found_q  <= 1'b0;
			status_q <= 1'b0;
		end else begin
			done_q <= (state_q == ST_UPD);
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						state_q <= ST_CMP;
					end
				end
				ST_CMP: begin
					state_q <= ST_UPD;
				end
				ST_UPD: begin
					state_q  <= ST_IDLE;
					found_q  <= is_lookup && hit_last;
					status_q <= is_ins && full;
					if (is_ins && !full) begin
						count_q <= count_q + CW'(1);
					end else if ((act_s1 == ACT_REMOVE) && hit_last) begin
						count_q <= count_q - CW'(1);
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			act_s1   <= cmd.action;
			value_s1 <= cmd.item_value;
		end
	end

	assign hit_chain[0] = 1'b0;

	for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
		logic signed [VALUE_W-1:0] left_d;
		logic signed [VALUE_W-1:0] right_d;

		if (g == 0) begin : g_first
			assign left_d = value_s1;
		end else begin : g_mid
			assign left_d = cell_data[g-1];
		end

		if (g == CAPACITY - 1) begin : g_last
			assign right_d = cell_data[g];
		end else begin : g_inner
			assign right_d = cell_data[g+1];
		end

		ovl_cell u_cell (
			.clk        (clk),
			.ctl        (ctl),
			.value      (value_s1),
			.valid      (count_q > CW'(g)),
			.at_tail    (count_q == CW'(g)),
			.left_data  (left_d),
			.right_data (right_d),
			.hit_in     (hit_chain[g]),
			.data       (cell_data[g]),
			.hit_out    (hit_chain[g+1])
		);
	end

	assign done = done_q;

	always_comb begin
		result.found       = found_q;
		result.is_empty    = (count_q == '0);
		result.head_value  = (count_q == '0) ? '0 : cell_data[0];
		result.entry_count = COUNT_OUT_W'(count_q);
		result.status      = status_q;
	end

`ifndef NO_ASSERTIONS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(CAPACITY))
		else $error("entry count above capacity");

	a_done_after_upd: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(state_q == ST_UPD))
		else $error("done without an update cycle");

	a_count_only_upd: assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(count_q) |-> $past(state_q == ST_UPD))
		else $error("count changed outside an update cycle");

	a_found_status: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !(result.found && result.status))
		else $error("found and full status together");
`endif

endmodule

// ===== tb/ordered_value_list_chk.sv =====
// Scoreboard for the ordered value list: models the list and checks every result transaction.
module ordered_value_list_chk import ovl_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    start,
	input  logic    busy,
	input  cmd_t    cmd,
	input  logic    done,
	input  result_t result,
	output int      errors,
	output int      pending
);
	timeunit 1ns;
	timeprecision 1ps;

	logic signed [VALUE_W-1:0] held [OVL_CAPACITY];
	int unsigned held_cnt = 0;
	result_t expected_results [$];
	int fail_cnt = 0;
	int queued = 0;

	assign errors  = fail_cnt;
	assign pending = queued;

	function automatic result_t apply_list_cmd(cmd_t c);
		result_t r;
		int unsigned pos;
		r = '0;
		case (c.action)
			ACT_HEAD, ACT_TAIL: begin
				if (held_cnt >= OVL_CAPACITY) begin
					r.status = 1'b1;
				end else begin
					if (c.action == ACT_HEAD) begin
						for (int i = held_cnt; i > 0; i--)
							held[i] = held[i-1];
						held[0] = c.item_value;
					end else begin
						held[held_cnt] = c.item_value;
					end
					held_cnt++;
				end
			end
			default: begin
				pos = held_cnt;
				for (int i = held_cnt - 1; i >= 0; i--)
					if (held[i] == c.item_value)
						pos = i;
				if (pos < held_cnt) begin
					r.found = 1'b1;
					if (c.action == ACT_REMOVE) begin
						for (int i = pos; i < held_cnt - 1; i++)
							held[i] = held[i+1];
						held_cnt--;
					end
				end
			end
		endcase
		r.is_empty    = (held_cnt == 0);
		r.head_value  = (held_cnt == 0) ? '0 : held[0];
		r.entry_count = held_cnt[COUNT_OUT_W-1:0];
		return r;
	endfunction

	always @(posedge clk) begin
		result_t exp_r;
		if (arst_n) begin
			if (done) begin
				if (expected_results.size() == 0) begin
					if (fail_cnt < 10)
						$display("%0t: result transaction with nothing outstanding", $realtime);
					fail_cnt++;
				end else begin
					exp_r = expected_results.pop_front();
					if (exp_r.found !== result.found || exp_r.is_empty !== result.is_empty ||
					    exp_r.head_value !== result.head_value ||
					    exp_r.entry_count !== result.entry_count ||
					    exp_r.status !== result.status) begin
						if (fail_cnt < 10)
							$display("%0t: mismatch exp found=%0b empty=%0b head=%0d cnt=%0d st=%0b",
							         $realtime, exp_r.found, exp_r.is_empty, exp_r.head_value,
							         exp_r.entry_count, exp_r.status,
							         " got found=%0b empty=%0b head=%0d cnt=%0d st=%0b",
							         result.found, result.is_empty, result.head_value,
							         result.entry_count, result.status);
						fail_cnt++;
					end
				end
			end
			if (start && !busy)
				expected_results.push_back(apply_list_cmd(cmd));
		end
		queued <= expected_results.size();
	end

endmodule

// ===== tb/ordered_value_list_tb.sv =====
// Testbench top for the ordered value list: clock, reset, command stimulus and verdict.
module ordered_value_list_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import ovl_pkg::*;

	localparam int RUN_ITEMS   = 1950;
	localparam int CYCLE_LIMIT = 200000;
	localparam logic signed [VALUE_W-1:0] VAL_MIN = 32'sh8000_0000;
	localparam logic signed [VALUE_W-1:0] VAL_MAX = 32'sh7fff_ffff;

	logic    clk;
	logic    arst_n = 1'b0;
	logic    start  = 1'b0;
	cmd_t    cmd    = '0;
	logic    busy;
	logic    done;
	result_t result;
	int      fail_cnt;
	int      queued;
	int      cycle_cnt = 0;
	int      sent = 0;
	bit      steady = 1'b0;
	logic signed [VALUE_W-1:0] pool [8];

	ordered_value_list u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done),
		.result (result)
	);

	ordered_value_list_chk u_chk (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.busy    (busy),
		.cmd     (cmd),
		.done    (done),
		.result  (result),
		.errors  (fail_cnt),
		.pending (queued)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt == CYCLE_LIMIT) begin
			$display("ordered_value_list verification failed");
			$finish;
		end
	end

	task automatic send(action_t act, logic signed [VALUE_W-1:0] val);
		if (!steady && $urandom_range(0, 99) < 7) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
		start <= 1'b1;
		cmd   <= '{action: act, item_value: val};
		do @(posedge clk); while (busy);
		sent++;
	endtask

	// hold off until every outstanding transaction has returned
	task automatic quiesce();
		start <= 1'b0;
		do @(posedge clk); while (queued != 0);
	endtask

	function automatic logic signed [VALUE_W-1:0] pick_value();
		if ($urandom_range(0, 9) == 0)
			return $urandom;
		return pool[$urandom_range(0, 7)];
	endfunction

	initial begin
		bit      grow;
		int      r;
		action_t act;
		grow = 1'b1;
		foreach (pool[i])
			pool[i] = $urandom;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty list, extremes, duplicates, removal at head, middle and tail
		send(ACT_SEARCH, 32'sd5);
		send(ACT_REMOVE, 32'sd5);
		send(ACT_HEAD, VAL_MIN);
		send(ACT_TAIL, VAL_MAX);
		send(ACT_HEAD, 32'sd0);
		send(ACT_TAIL, -32'sd1);
		send(ACT_HEAD, 32'sd7);
		send(ACT_TAIL, 32'sd7);
		send(ACT_SEARCH, VAL_MAX);
		send(ACT_SEARCH, 32'sd12345);
		send(ACT_REMOVE, 32'sd7);
		send(ACT_REMOVE, -32'sd1);
		send(ACT_REMOVE, 32'sd7);
		// fill up, then inserts into a full list
		for (int i = 0; i < 13; i++)
			send((i % 2) ? ACT_TAIL : ACT_HEAD, $urandom);
		send(ACT_HEAD, 32'sd1);
		send(ACT_TAIL, 32'sd2);
		send(ACT_REMOVE, 32'sd0);
		quiesce();

		for (int n = 0; sent < RUN_ITEMS; n++) begin
			if (n % 60 == 0)
				grow = $urandom_range(0, 1);
			steady = (n >= 400 && n < 700);
			if (n == 900)
				quiesce();
			if ($urandom_range(0, 19) == 0)
				pool[$urandom_range(0, 7)] = ($urandom_range(0, 3) == 0) ?
					(($urandom_range(0, 1) == 0) ? VAL_MIN : VAL_MAX) : $urandom;
			r = $urandom_range(0, 99);
			if (grow)
				act = (r < 30) ? ACT_HEAD : (r < 60) ? ACT_TAIL :
				      (r < 80) ? ACT_REMOVE : ACT_SEARCH;
			else
				act = (r < 15) ? ACT_HEAD : (r < 30) ? ACT_TAIL :
				      (r < 75) ? ACT_REMOVE : ACT_SEARCH;
			send(act, pick_value());
		end

		quiesce();
		repeat (8) @(posedge clk);
		if (fail_cnt == 0)
			$display("ordered_value_list verification clean");
		else
			$display("ordered_value_list verification failed");
		$finish;
	end

endmodule
